// ----- design/hnfe_pkg.sv -----
// ----------------------------------------------------------------------------
// hnfe_pkg: shared types and constants for the HDLC NRZI frame encoder
// Request codes, line constants, channel payload structs, queue entry and
// back-end state encoding.
// ----------------------------------------------------------------------------
package hnfe_pkg;

  // request codes on in_data.req_type
  localparam logic [1:0] REQ_FLAG = 2'd0;
  localparam logic [1:0] REQ_DATA = 2'd1;
  localparam logic [1:0] REQ_END  = 2'd2;

  localparam logic [7:0]  FLAG_BYTE   = 8'h7E;
  localparam logic [2:0]  STUFF_LIMIT = 3'd5;
  localparam logic [15:0] FCS_POLY    = 16'h8408;
  localparam logic [15:0] FCS_INIT    = 16'hFFFF;

  localparam int QUEUE_DEPTH = 2;

  typedef struct packed {
    logic [1:0] req_type;
    logic [7:0] data_byte;
  } in_item_t;

  typedef struct packed {
    logic line_level;
    logic stuffed;
    logic last;
  } out_item_t;

  typedef enum logic [1:0] {
    CMD_FLAG,
    CMD_DATA,
    CMD_END
  } cmd_kind_t;

  typedef struct packed {
    cmd_kind_t  kind;
    logic [7:0] data_byte;
  } cmd_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

  typedef enum logic [2:0] {
    BK_IDLE,
    BK_DATA,
    BK_FCS_LO,
    BK_FCS_HI,
    BK_FLAG
  } bk_state_t;

endpackage

// ----- design/hnfe_front.sv -----
// ----------------------------------------------------------------------------
// hnfe_front: request intake
// Accepts requests, decodes the request code into a queue command and drops
// the unused code.
// ----------------------------------------------------------------------------
module hnfe_front (
  input  logic                in_valid,
  output logic                in_stall,
  input  hnfe_pkg::in_item_t  in_data,
  input  hnfe_pkg::q_status_t q_st,
  output logic                push,
  output hnfe_pkg::cmd_t      push_cmd
);
  import hnfe_pkg::*;

  logic accept;
  logic known;

  assign in_stall = q_st.full;
  assign accept   = in_valid && !in_stall;

  always_comb begin
    known         = 1'b1;
    push_cmd.kind = CMD_FLAG;
    unique case (in_data.req_type)
      REQ_FLAG: push_cmd.kind = CMD_FLAG;
      REQ_DATA: push_cmd.kind = CMD_DATA;
      REQ_END:  push_cmd.kind = CMD_END;
      default:  known = 1'b0;
    endcase
    push_cmd.data_byte = in_data.data_byte;
  end

  assign push = accept && known;

endmodule

// ----- design/hnfe_queue.sv -----
// ----------------------------------------------------------------------------
// hnfe_queue: command queue
// Short FIFO between the intake and the bit serializer.
// ----------------------------------------------------------------------------
module hnfe_queue #(
  parameter int DEPTH = hnfe_pkg::QUEUE_DEPTH
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                push,
  input  hnfe_pkg::cmd_t      push_cmd,
  input  logic                pop,
  output hnfe_pkg::cmd_t      head,
  output hnfe_pkg::q_status_t q_st
);
  import hnfe_pkg::*;

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  cmd_t          mem_r [DEPTH];
  logic [PW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic          do_push, do_pop;

  assign q_st.full  = (cnt_r == CW'(DEPTH));
  assign q_st.empty = (cnt_r == '0);
  assign do_push    = push && !q_st.full;
  assign do_pop     = pop && !q_st.empty;
  assign head       = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PW'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PW'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_cmd;
    end
  end

endmodule

// ----- design/hnfe_back.sv -----
// ----------------------------------------------------------------------------
// hnfe_back: bit serializer
// Sends one line bit per cycle while the output is not stalled: bit stuffing,
// FCS update, NRZI coding and the output register.
// ----------------------------------------------------------------------------
module hnfe_back (
  input  logic                 clk,
  input  logic                 rst_n,
  input  hnfe_pkg::cmd_t       head,
  input  hnfe_pkg::q_status_t  q_st,
  output logic                 pop,
  output logic                 out_valid,
  input  logic                 out_stall,
  output hnfe_pkg::out_item_t  out_data
);
  import hnfe_pkg::*;

  bk_state_t   state_r, state_nxt, load_state;
  logic [3:0]  idx_r, idx_nxt;
  logic        stuff_r, stuff_nxt;
  logic [2:0]  ones_r, ones_nxt;
  logic [15:0] fcs_r, fcs_nxt;
  logic        lvl_r, lvl_nxt;
  logic [7:0]  byte_r;
  logic        out_valid_r, out_valid_nxt;
  out_item_t   out_data_r, out_data_nxt;

  logic [7:0]  cur_byte;
  logic        cur_bit;
  logic        line_bit;
  logic        stuff_set;
  logic        byte_done;
  logic        item_done;
  logic        busy;
  logic        advance;
  logic [2:0]  ones_inc;

  assign busy    = (state_r != BK_IDLE);
  assign advance = busy && (!out_valid_r || !out_stall);

  always_comb begin
    unique case (head.kind)
      CMD_FLAG: load_state = BK_FLAG;
      CMD_DATA: load_state = BK_DATA;
      CMD_END:  load_state = BK_FCS_LO;
      default:  load_state = BK_IDLE;
    endcase
  end

  always_comb begin
    unique case (state_r)
      BK_DATA:   cur_byte = byte_r;
      BK_FCS_LO: cur_byte = ~fcs_r[7:0];
      BK_FCS_HI: cur_byte = ~fcs_r[15:8];
      BK_FLAG:   cur_byte = FLAG_BYTE;
      default:   cur_byte = '0;
    endcase
  end

  assign cur_bit   = cur_byte[idx_r[2:0]];
  assign line_bit  = stuff_r ? 1'b0 : cur_bit;
  assign ones_inc  = ones_r + 3'd1;
  // no stuffing inside a flag
  assign stuff_set = !stuff_r && (state_r != BK_FLAG) && cur_bit && (ones_inc >= STUFF_LIMIT);
  assign byte_done = stuff_r ? (idx_r == 4'd8) : ((idx_r == 4'd7) && !stuff_set);
  assign item_done = byte_done && ((state_r == BK_DATA) || (state_r == BK_FLAG));
  assign pop       = !q_st.empty &&
                     ((state_r == BK_IDLE) || (advance && item_done));

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      BK_IDLE: begin
        if (!q_st.empty) state_nxt = load_state;
      end
      BK_FCS_LO: begin
        if (advance && byte_done) state_nxt = BK_FCS_HI;
      end
      BK_FCS_HI: begin
        if (advance && byte_done) state_nxt = BK_FLAG;
      end
      default: begin
        if (advance && byte_done) begin
          state_nxt = q_st.empty ? BK_IDLE : load_state;
        end
      end
    endcase
  end

  // datapath and outputs
  always_comb begin
    idx_nxt       = idx_r;
    stuff_nxt     = stuff_r;
    ones_nxt      = ones_r;
    fcs_nxt       = fcs_r;
    lvl_nxt       = lvl_r;
    out_data_nxt  = out_data_r;
    out_valid_nxt = out_valid_r;
    if (advance) begin
      lvl_nxt                 = line_bit ? lvl_r : ~lvl_r;
      out_valid_nxt           = 1'b1;
      out_data_nxt.line_level = line_bit ? lvl_r : ~lvl_r;
      out_data_nxt.stuffed    = stuff_r;
      out_data_nxt.last       = item_done;
      if (stuff_r) begin
        stuff_nxt = 1'b0;
        ones_nxt  = '0;
      end else begin
        idx_nxt = idx_r + 4'd1;
        if (state_r != BK_FLAG) begin
          ones_nxt  = cur_bit ? ones_inc : 3'd0;
          stuff_nxt = stuff_set;
        end
        if (state_r == BK_DATA) begin
          fcs_nxt = (fcs_r >> 1) ^ ((fcs_r[0] ^ cur_bit) ? FCS_POLY : 16'h0000);
        end
      end
      if (byte_done) begin
        idx_nxt = '0;
        if (state_r == BK_FLAG) begin
          ones_nxt = '0;
          fcs_nxt  = FCS_INIT;
        end
      end
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= BK_IDLE;
      idx_r       <= '0;
      stuff_r     <= 1'b0;
      ones_r      <= '0;
      fcs_r       <= FCS_INIT;
      lvl_r       <= 1'b1;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      idx_r       <= idx_nxt;
      stuff_r     <= stuff_nxt;
      ones_r      <= ones_nxt;
      fcs_r       <= fcs_nxt;
      lvl_r       <= lvl_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      byte_r <= head.data_byte;
    end
    out_data_r <= out_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  a_stuff_after_run: assert property (@(posedge clk) disable iff (!rst_n)
    stuff_r |-> (ones_r == STUFF_LIMIT))
    else $error("stuff pending without a full run of ones");

  a_no_stuff_in_flag: assert property (@(posedge clk) disable iff (!rst_n)
    stuff_r |-> (state_r != BK_FLAG) && (state_r != BK_IDLE))
    else $error("stuff pending in flag or idle");

  a_idle_clean: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == BK_IDLE) |-> (idx_r == 4'd0) && !stuff_r)
    else $error("idle with bit position not cleared");

  a_hold_stalled: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_stall) |=> out_valid_r && $stable(out_data_r)
      && $stable(lvl_r))
    else $error("output or line level moved while stalled");

  a_flag_resets_fcs: assert property (@(posedge clk) disable iff (!rst_n)
    (advance && byte_done && (state_r == BK_FLAG)) |=>
      (fcs_r == FCS_INIT) && (ones_r == 3'd0))
    else $error("flag did not reset FCS and ones run");

endmodule

// ----- design/hdlc_nrzi_frame_encoder_top.sv -----
// ----------------------------------------------------------------------------
// hdlc_nrzi_frame_encoder_top: HDLC frame bit encoder with NRZI line coding
// Turns flag, data and end-of-frame requests into a stream of line bits.
// ----------------------------------------------------------------------------
// Usage:
//   in_valid/in_stall/in_data carry one request (flag, data byte or end of
//   frame). Request code 3 is taken and dropped with no line bits.
//   out_valid/out_stall/out_data carry one line bit per transfer: NRZI level,
//   a stuffing marker and a last marker on the final bit of each request.
//   A flag gives 8 bits, a data byte 8 to 10, end of frame 24 to 28.
//   Throughput: one line bit per cycle from the serializer while the output
//   is not stalled; requests queue in a 2-entry command FIFO and a queued
//   one starts right after the previous last bit, with no idle state between.
//   From idle, a taken request passes the queue, the serializer state
//   register and the output register before its first line bit appears.
//   Reset: line level mark, ones run cleared, FCS 0xFFFF, queue empty.
//   When out_stall is high while out_valid is set, the serializer holds;
//   requests keep being taken until the queue fills, then in_stall rises.
// ----------------------------------------------------------------------------
module hdlc_nrzi_frame_encoder_top #(
  parameter int QDEPTH = hnfe_pkg::QUEUE_DEPTH
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  hnfe_pkg::in_item_t  in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output hnfe_pkg::out_item_t out_data
);
  import hnfe_pkg::*;

  q_status_t q_st;
  logic      push;
  cmd_t      push_cmd;
  logic      pop;
  cmd_t      head;

  hnfe_front u_front (
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .q_st     (q_st),
    .push     (push),
    .push_cmd (push_cmd)
  );

  hnfe_queue #(
    .DEPTH (QDEPTH)
  ) u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_cmd (push_cmd),
    .pop      (pop),
    .head     (head),
    .q_st     (q_st)
  );

  hnfe_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .head      (head),
    .q_st      (q_st),
    .pop       (pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule

// ----- dv/hdlc_nrzi_frame_encoder_top_test.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// hdlc_nrzi_frame_encoder_top_test: self-checking bench for the frame encoder
// Sends directed and random flag/data/end requests, predicts every line bit
// (bit stuffing, X.25 FCS, NRZI) and checks each bit in order under random
// idle gaps on the request side and random stalls on the line side.
// ----------------------------------------------------------------------------
module hdlc_nrzi_frame_encoder_top_test;
  import hnfe_pkg::*;

  localparam logic [1:0] REQ_UNUSED = 2'd3;
  localparam int         QUIET_TAIL = 20;

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      in_valid = 1'b0;
  logic      in_stall;
  in_item_t  in_data = '0;
  logic      out_valid;
  logic      out_stall = 1'b0;
  out_item_t out_data;

  hdlc_nrzi_frame_encoder_top u_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data)
  );

  always #6 clk = ~clk;

  // pending requests and expected line bits
  in_item_t  req_q[$];
  out_item_t line_bits_q[$];

  // predicted encoder state
  logic        line_lvl;
  logic [2:0]  ones_cnt;
  logic [15:0] fcs_acc;

  int n_total;
  int n_taken;
  int n_frames;
  int n_bits;
  int n_stuff;
  int n_errs;
  logic in_taken;
  int   in_gap;
  int   out_gap;

  function automatic void push_line_bit(logic b, logic stf);
    if (!b) line_lvl = ~line_lvl;
    line_bits_q.push_back('{line_level: line_lvl, stuffed: stf, last: 1'b0});
  endfunction

  function automatic void emit_stuffed_byte(logic [7:0] by, bit fold);
    logic b;
    logic mix;
    for (int i = 0; i < 8; i++) begin
      b = by[i];
      if (fold) begin
        mix = fcs_acc[0] ^ b;
        fcs_acc = fcs_acc >> 1;
        if (mix) fcs_acc = fcs_acc ^ FCS_POLY;
      end
      push_line_bit(b, 1'b0);
      ones_cnt = b ? ones_cnt + 3'd1 : 3'd0;
      if (ones_cnt >= STUFF_LIMIT) begin
        push_line_bit(1'b0, 1'b1);
        ones_cnt = '0;
      end
    end
  endfunction

  function automatic void emit_flag();
    for (int i = 0; i < 8; i++) push_line_bit(FLAG_BYTE[i], 1'b0);
    ones_cnt = '0;
    fcs_acc  = FCS_INIT;
  endfunction

  function automatic void encode_request(in_item_t it);
    int        n0;
    logic [15:0] fcs_out;
    out_item_t tail;
    n0 = line_bits_q.size();
    case (it.req_type)
      REQ_FLAG: begin
        emit_flag();
      end
      REQ_DATA: begin
        emit_stuffed_byte(it.data_byte, 1'b1);
      end
      REQ_END: begin
        fcs_out = ~fcs_acc;
        emit_stuffed_byte(fcs_out[7:0], 1'b0);
        emit_stuffed_byte(fcs_out[15:8], 1'b0);
        emit_flag();
      end
      default: ;
    endcase
    if (line_bits_q.size() > n0) begin
      tail = line_bits_q.pop_back();
      tail.last = 1'b1;
      line_bits_q.push_back(tail);
    end
  endfunction

  function automatic void add_req(logic [1:0] kind, logic [7:0] by);
    req_q.push_back('{req_type: kind, data_byte: by});
  endfunction

  function automatic logic [7:0] pick_payload();
    case ($urandom_range(0, 5))
      0:       return 8'hFF;
      1:       return 8'h7E;
      2:       return {3'b000, 5'h1F} << $urandom_range(0, 3);
      default: return 8'($urandom);
    endcase
  endfunction

  // request driver
  always @(negedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      in_gap = 0;
    end else if (in_valid && !in_taken) begin
      // held until taken
    end else if (in_gap > 0) begin
      in_gap = in_gap - 1;
      in_valid <= 1'b0;
    end else if (n_taken < n_total - QUIET_TAIL && $urandom_range(0, 5) == 0) begin
      in_gap = $urandom_range(1, 11) - 1;
      in_valid <= 1'b0;
    end else if (req_q.size() > 0) begin
      in_data  <= req_q.pop_front();
      in_valid <= 1'b1;
    end else begin
      in_valid <= 1'b0;
    end
  end

  // line-side stall driver
  always @(negedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
      out_gap = 0;
    end else if (out_gap > 0) begin
      out_gap = out_gap - 1;
      out_stall <= 1'b1;
    end else if (n_taken < n_total - QUIET_TAIL && $urandom_range(0, 7) == 0) begin
      out_gap = $urandom_range(1, 11) - 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  // request acceptance and line bit checking
  always @(posedge clk) begin
    out_item_t want;
    if (!rst_n) begin
      in_taken <= 1'b0;
    end else begin
      in_taken <= in_valid && !in_stall;
      if (in_valid && !in_stall) begin
        encode_request(in_data);
        n_taken = n_taken + 1;
      end
      if (out_valid && !out_stall) begin
        if (line_bits_q.size() == 0) begin
          $error("unexpected line bit: level %0b stuffed %0b last %0b",
                 out_data.line_level, out_data.stuffed, out_data.last);
          n_errs = n_errs + 1;
        end else begin
          want = line_bits_q.pop_front();
          n_bits = n_bits + 1;
          if (out_data.stuffed) n_stuff = n_stuff + 1;
          if (out_data.line_level !== want.line_level) begin
            $error("line_level: expected %0b actual %0b", want.line_level,
                   out_data.line_level);
            n_errs = n_errs + 1;
          end
          if (out_data.stuffed !== want.stuffed) begin
            $error("stuffed: expected %0b actual %0b", want.stuffed, out_data.stuffed);
            n_errs = n_errs + 1;
          end
          if (out_data.last !== want.last) begin
            $error("last: expected %0b actual %0b", want.last, out_data.last);
            n_errs = n_errs + 1;
          end
        end
      end
    end
  end

  initial begin
    #(5_000_000);
    $display("hdlc_nrzi_frame_encoder_top_test failed");
    $finish;
  end

  initial begin
    int nbytes;
    int noise;
    int drain;
    line_lvl = 1'b1;
    ones_cnt = '0;
    fcs_acc  = FCS_INIT;
    n_taken  = 0;
    n_frames = 0;
    n_bits   = 0;
    n_stuff  = 0;
    n_errs   = 0;

    // directed: data before any flag, stuffing runs across bytes, unused code,
    // ignored payload on flag/end, back-to-back end requests
    add_req(REQ_DATA, 8'hFF);
    add_req(REQ_FLAG, 8'h00);
    add_req(REQ_DATA, 8'h00);
    add_req(REQ_DATA, 8'hFF);
    add_req(REQ_DATA, 8'hFF);
    add_req(REQ_DATA, 8'h55);
    add_req(REQ_DATA, 8'hAA);
    add_req(REQ_DATA, 8'h80);
    add_req(REQ_DATA, 8'h01);
    add_req(REQ_UNUSED, 8'hFF);
    add_req(REQ_DATA, 8'h7E);
    add_req(REQ_DATA, 8'h1F);
    add_req(REQ_DATA, 8'hF8);
    add_req(REQ_END, 8'hFF);
    add_req(REQ_END, 8'h00);
    add_req(REQ_UNUSED, 8'h00);
    add_req(REQ_FLAG, 8'hFF);
    add_req(REQ_DATA, 8'hF0);
    add_req(REQ_DATA, 8'h0F);
    add_req(REQ_END, 8'hA5);
    n_frames = 3;

    // random frames: mostly flag, payload, end; some noise and broken frames
    while (req_q.size() < 95) begin
      noise = $urandom_range(0, 9);
      if (noise != 0) add_req(REQ_FLAG, 8'($urandom));
      nbytes = $urandom_range(0, 6);
      for (int i = 0; i < nbytes; i++) begin
        if ($urandom_range(0, 15) == 0) add_req(REQ_UNUSED, 8'($urandom));
        add_req(REQ_DATA, pick_payload());
      end
      if (noise != 1) add_req(REQ_END, 8'($urandom));
      n_frames = n_frames + 1;
    end
    n_total = req_q.size();

    repeat (8) @(negedge clk);
    rst_n = 1'b1;

    while (req_q.size() > 0 || in_valid) @(posedge clk);
    while (line_bits_q.size() > 0) @(posedge clk);
    drain = 0;
    while (drain < 40) begin
      @(posedge clk);
      drain = drain + 1;
    end

    $display("Sent %0d requests over %0d frames; checked %0d line bits, %0d of them stuffing.",
             n_total, n_frames, n_bits, n_stuff);
    if (n_errs == 0 && line_bits_q.size() == 0) begin
      $display("hdlc_nrzi_frame_encoder_top_test passed");
    end else begin
      $display("hdlc_nrzi_frame_encoder_top_test failed");
    end
    $finish;
  end

endmodule

// ----- files.f -----
design/hnfe_pkg.sv
design/hnfe_front.sv
design/hnfe_queue.sv
design/hnfe_back.sv
design/hdlc_nrzi_frame_encoder_top.sv
dv/hdlc_nrzi_frame_encoder_top_test.sv
